// ===== design/vidt_pkg.sv =====
// shared types and constants of the valve id table frame emitter
package vidt_pkg;

	// request codes
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_ADD   = 2'd1;
	localparam logic [1:0] REQ_SEND  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DUP    = 2'd1;
	localparam logic [1:0] ST_UNUSED = 2'd2;

	// frame byte positions
	localparam logic [4:0] POS_SYNC0 = 5'd0;
	localparam logic [4:0] POS_SYNC1 = 5'd1;
	localparam logic [4:0] POS_ID0   = 5'd2;
	localparam logic [4:0] POS_ID1   = 5'd3;
	localparam logic [4:0] POS_ID2   = 5'd4;
	localparam logic [4:0] POS_ID3   = 5'd5;
	localparam logic [4:0] POS_KEY   = 5'd6;
	localparam logic [4:0] POS_SET0  = 5'd19;
	localparam logic [4:0] POS_SET1  = 5'd20;
	localparam logic [4:0] POS_SET2  = 5'd21;
	localparam logic [4:0] POS_SET3  = 5'd22;
	localparam logic [4:0] POS_CHECK = 5'd27;

	localparam logic [7:0] SYNC_BYTE = 8'hff;

	// control from the sequencer to the frame generator
	typedef struct packed {
		logic start;
		logic step;
	} fg_ctrl_t;

	// current byte from the frame generator
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} fg_stat_t;

endpackage

// ===== design/vidt_id_ram.sv =====
// identifier table memory, one write and one registered read port
module vidt_id_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/vidt_frame_gen.sv =====
// frame byte generator with running checksum
module vidt_frame_gen (
	input  logic               clk,
	input  logic               arst_n,
	input  vidt_pkg::fg_ctrl_t ctrl,
	input  logic [31:0]        valve_id,
	input  logic [7:0]         key_code,
	input  logic [31:0]        set_word,
	output vidt_pkg::fg_stat_t stat
);

	logic [4:0] byte_cnt_q;
	logic [7:0] xor_q;
	logic [7:0] cur_byte;

	always_comb begin
		unique case (byte_cnt_q)
			vidt_pkg::POS_SYNC0: cur_byte = vidt_pkg::SYNC_BYTE;
			vidt_pkg::POS_SYNC1: cur_byte = vidt_pkg::SYNC_BYTE;
			vidt_pkg::POS_ID0:   cur_byte = valve_id[31:24];
			vidt_pkg::POS_ID1:   cur_byte = valve_id[23:16];
			vidt_pkg::POS_ID2:   cur_byte = valve_id[15:8];
			vidt_pkg::POS_ID3:   cur_byte = valve_id[7:0];
			vidt_pkg::POS_KEY:   cur_byte = key_code;
			vidt_pkg::POS_SET0:  cur_byte = set_word[31:24];
			vidt_pkg::POS_SET1:  cur_byte = set_word[23:16];
			vidt_pkg::POS_SET2:  cur_byte = set_word[15:8];
			vidt_pkg::POS_SET3:  cur_byte = set_word[7:0];
			vidt_pkg::POS_CHECK: cur_byte = ~xor_q;
			default:             cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			xor_q      <= '0;
		end else if (ctrl.start) begin
			byte_cnt_q <= '0;
			xor_q      <= '0;
		end else if (ctrl.step) begin
			byte_cnt_q <= byte_cnt_q + 5'd1;
			xor_q      <= xor_q ^ cur_byte;
		end
	end

	assign stat.data = cur_byte;
	assign stat.last = (byte_cnt_q == vidt_pkg::POS_CHECK);

endmodule

// ===== design/valve_id_table_frame_emitter_core.sv =====
// valve id table with duplicate search and 28-byte frame emitter, top level
// clear, failed send: one result via the S_RESP state and the output register; add: table
// walk, one table read per cycle, compared when the data returns; the result follows via S_RESP
// send: 28 results, the first via S_LOAD and S_FRAME, then one byte per cycle
// out of the output register; stall pauses it; next request taken once the last is loaded
// reset clears the fill count and control state; table contents stay undefined
module valve_id_table_frame_emitter_core #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] valve_id,
	input  logic [3:0]  entry_index,
	input  logic [7:0]  key_code,
	input  logic [31:0] set_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  status,
	output logic        last_byte
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int IW = (AW > 4) ? AW : 4;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRCH  = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_FRAME = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] count_q;
	logic [AW-1:0] ptr_q;
	logic          chk_q;
	logic [1:0]    resp_q;
	logic [31:0]   vid_q;
	logic [3:0]    idx_q;
	logic [7:0]    key_q;
	logic [31:0]   set_q;

	logic          in_acc;
	logic          out_free;
	logic          issue;
	logic          match;
	logic          srch_done;
	logic [IW-1:0] idx_ext;
	logic [IW-1:0] in_idx_ext;
	logic [IW-1:0] count_ext;
	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	vidt_pkg::fg_ctrl_t fg_ctrl;
	vidt_pkg::fg_stat_t fg_stat;

	logic       out_valid_q;
	logic       out_load;
	logic [7:0] out_byte_q;
	logic [1:0] status_q;
	logic       last_q;
	logic [7:0] load_byte;
	logic [1:0] load_status;
	logic       load_last;

	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;

	assign idx_ext    = IW'(idx_q);
	assign in_idx_ext = IW'(entry_index);
	assign count_ext  = IW'(count_q);

	// table walk: one read issued per cycle, compared when the data returns
	assign issue     = (state_q == S_SRCH) && (ptr_q != count_q);
	assign match     = (state_q == S_SRCH) && chk_q && (ram_rdata == vid_q);
	assign srch_done = (state_q == S_SRCH) && !match && !issue && !chk_q;

	assign ram_we    = srch_done;
	assign ram_re    = issue || (state_q == S_LOAD);
	assign ram_raddr = (state_q == S_LOAD) ? idx_ext[AW-1:0] : ptr_q;

	vidt_id_ram #(
		.DEPTH(TABLE_ENTRIES),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q),
		.wdata(vid_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign fg_ctrl.start = (state_q == S_LOAD);
	assign fg_ctrl.step  = (state_q == S_FRAME) && out_free;

	vidt_frame_gen u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (fg_ctrl),
		.valve_id(ram_rdata),
		.key_code(key_q),
		.set_word(set_q),
		.stat    (fg_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			chk_q   <= 1'b0;
			resp_q  <= vidt_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						ptr_q  <= '0;
						chk_q  <= 1'b0;
						resp_q <= vidt_pkg::ST_OK;
						priority if (req_type == vidt_pkg::REQ_CLEAR) begin
							count_q <= '0;
							state_q <= S_RESP;
						end else if (req_type == vidt_pkg::REQ_ADD) begin
							state_q <= S_SRCH;
						end else if (req_type == vidt_pkg::REQ_SEND) begin
							if (in_idx_ext >= count_ext) begin
								resp_q  <= vidt_pkg::ST_UNUSED;
								state_q <= S_RESP;
							end else begin
								state_q <= S_LOAD;
							end
						end else begin
							// unused request code is dropped
							state_q <= S_IDLE;
						end
					end
				end
				S_SRCH: begin
					chk_q <= issue;
					if (issue) begin
						ptr_q <= ptr_q + AW'(1);
					end
					priority if (match) begin
						resp_q  <= vidt_pkg::ST_DUP;
						state_q <= S_RESP;
					end else if (srch_done) begin
						if (count_q == AW'(TABLE_ENTRIES - 1)) begin
							count_q <= '0;
						end else begin
							count_q <= count_q + AW'(1);
						end
						state_q <= S_RESP;
					end
				end
				S_LOAD: begin
					state_q <= S_FRAME;
				end
				S_FRAME: begin
					if (out_free && fg_stat.last) begin
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_comb begin
		out_load    = 1'b0;
		load_byte   = 8'h00;
		load_status = resp_q;
		load_last   = 1'b1;
		if (state_q == S_RESP && out_free) begin
			out_load = 1'b1;
		end else if (state_q == S_FRAME && out_free) begin
			out_load    = 1'b1;
			load_byte   = fg_stat.data;
			load_status = vidt_pkg::ST_OK;
			load_last   = fg_stat.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= load_byte;
			status_q   <= load_status;
			last_q     <= load_last;
		end
		if (in_acc) begin
			vid_q <= valve_id;
			idx_q <= entry_index;
			key_q <= key_code;
			set_q <= set_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign status    = status_q;
	assign last_byte = last_q;

	// fill count never reaches the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= AW'(TABLE_ENTRIES - 1))
		else $error("fill count out of range");

	// a failed or one-result request always ends its sequence
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != vidt_pkg::ST_OK) |-> last_byte)
		else $error("non-ok status without last marker");

	// after the checksum byte is loaded the sequencer is idle again
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FRAME) && out_free && fg_stat.last |=> (state_q == S_IDLE))
		else $error("frame did not end after checksum byte");

	// the table is written only at the end of a search without a match
	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (state_q == S_RESP) && (resp_q == vidt_pkg::ST_OK))
		else $error("table write outside a successful add");

endmodule
